// ----- src/cds_pkg.sv -----
// shared types, constants and calendar functions for the date stepper
package cds_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_DAYS  = 2'd1,
        ACT_MONTH = 2'd2,
        ACT_YEAR  = 2'd3
    } t_action;

    // date fields plus the year's residue modulo 400
    typedef struct packed {
        logic [4:0] day;
        logic [3:0] month;
        logic [8:0] mod400;
    } t_date;

    localparam int unsigned MOD_YEARS    = 400;
    // ceil(2^25 / 400), floor(y * RECIP_400 >> RECIP_SHIFT) is y / 400 for any 16-bit y
    localparam logic [16:0] RECIP_400    = 17'd83887;
    localparam int unsigned RECIP_SHIFT  = 25;
    localparam int unsigned YEAR_RST     = 1970;
    localparam logic [8:0]  MOD_RST      = 9'd370;
    localparam logic [4:0]  DAY_FIRST    = 5'd1;
    localparam logic [4:0]  DAY_LEAP     = 5'd29;
    localparam logic [4:0]  DAY_FEB_LAST = 5'd28;
    localparam logic [3:0]  MONTH_JAN    = 4'd1;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;

    function automatic logic is_leap(input logic [8:0] res, input logic [1:0] lsb);
        logic century;
        century = (res == 9'd100) || (res == 9'd200) || (res == 9'd300);
        return (res == 9'd0) || ((lsb == 2'd0) && !century);
    endfunction

    // zero for a month code outside 1 to 12
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- src/calendar_date_stepper_top.sv -----
// top level of the gregorian date stepper: sequencer, date registers, result strobe
// month and year steps: o_valid in the cycle after the accept, busy stays low, one word a cycle
// add days: one shared step per day in ST_COUNT, busy meanwhile, o_valid with the last step;
//   a zero count gives o_valid in the cycle after the accept; a new word may start in the strobe cycle
// load: reciprocal multiply, multiply back, then the date check, each step registered
// synchronous reset gives 1.1.1970 with the error flag clear; the receiver cannot stall
module calendar_date_stepper_top #(
    parameter int unsigned YEAR_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [5:0]  i_new_day,
    input  logic [3:0]  i_new_month,
    input  logic [15:0] i_new_year,
    input  logic [15:0] i_day_count,
    output logic        o_valid,
    output logic [4:0]  o_cur_day,
    output logic [3:0]  o_cur_month,
    output logic [15:0] o_cur_year,
    output logic        o_load_error
);
    import cds_pkg::*;

    // bits of the loaded year that survive the year width
    localparam int unsigned LW = (YEAR_WIDTH < 16) ? YEAR_WIDTH : 16;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_REDUCE = 3'b010,
        ST_COUNT  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    t_date                 r_date, n_date;
    logic [YEAR_WIDTH-1:0] r_year, n_year;
    logic                  r_err, n_err;
    logic                  r_valid, n_valid;
    logic [15:0]           r_cnt, n_cnt;

    // captured load word
    logic [5:0]            r_nd;
    logic [3:0]            r_nm;
    logic [YEAR_WIDTH-1:0] r_ny;

    logic                  w_accept;
    logic                  w_rstart;
    logic                  w_rdone;
    logic [8:0]            w_rem;
    t_action               w_op;
    t_date                 w_sdate;
    logic [YEAR_WIDTH-1:0] w_syear;
    logic                  w_ld_leap;
    logic [4:0]            w_ld_len;
    logic                  w_ld_ok;

    assign w_accept = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);

    // the step unit counts days while in ST_COUNT, otherwise serves the incoming word
    assign w_op = (r_state == ST_COUNT) ? ACT_DAYS : t_action'(i_action);

    cds_step #(
        .YEAR_WIDTH(YEAR_WIDTH)
    ) u_step (
        .i_op   (w_op),
        .i_date (r_date),
        .i_year (r_year),
        .o_date (w_sdate),
        .o_year (w_syear)
    );

    cds_mod400 u_mod400 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_rstart),
        .i_value (16'(i_new_year[LW-1:0])),
        .o_done  (w_rdone),
        .o_rem   (w_rem)
    );

    // load check once the residue of the loaded year is known
    always_comb begin
        w_ld_leap = is_leap(w_rem, r_ny[1:0]);
        w_ld_len  = month_len(r_nm, w_ld_leap);
        w_ld_ok   = (w_ld_len != 5'd0) && (r_nd != 6'd0) && (r_nd <= {1'b0, w_ld_len});
    end

    always_comb begin
        n_state  = r_state;
        n_date   = r_date;
        n_year   = r_year;
        n_err    = r_err;
        n_cnt    = r_cnt;
        n_valid  = 1'b0;
        w_rstart = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (t_action'(i_action))
                        ACT_LOAD: begin
                            w_rstart = 1'b1;
                            n_state  = ST_REDUCE;
                        end
                        ACT_DAYS: begin
                            if (i_day_count == 16'd0) begin
                                n_valid = 1'b1;
                            end else begin
                                n_cnt   = i_day_count;
                                n_state = ST_COUNT;
                            end
                        end
                        ACT_MONTH, ACT_YEAR: begin
                            n_date  = w_sdate;
                            n_year  = w_syear;
                            n_valid = 1'b1;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_REDUCE: begin
                if (w_rdone) begin
                    if (w_ld_ok) begin
                        n_date.day    = r_nd[4:0];
                        n_date.month  = r_nm;
                        n_date.mod400 = w_rem;
                        n_year        = r_ny;
                        n_err         = 1'b0;
                    end else begin
                        // invalid date falls back to the epoch
                        n_date.day    = DAY_FIRST;
                        n_date.month  = MONTH_JAN;
                        n_date.mod400 = MOD_RST;
                        n_year        = YEAR_WIDTH'(YEAR_RST);
                        n_err         = 1'b1;
                    end
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_COUNT: begin
                n_date = w_sdate;
                n_year = w_syear;
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == 16'd1) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_date.day    <= DAY_FIRST;
            r_date.month  <= MONTH_JAN;
            r_date.mod400 <= MOD_RST;
            r_year        <= YEAR_WIDTH'(YEAR_RST);
            r_err         <= 1'b0;
            r_valid       <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_state <= n_state;
            r_date  <= n_date;
            r_year  <= n_year;
            r_err   <= n_err;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
    end

    // load word held for the check at the end of the reduction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_nd <= i_new_day;
            r_nm <= i_new_month;
            r_ny <= YEAR_WIDTH'(i_new_year[LW-1:0]);
        end
    end

    // results read straight from the date registers
    assign o_valid      = r_valid;
    assign o_cur_day    = r_date.day;
    assign o_cur_month  = r_date.month;
    assign o_cur_year   = 16'(r_year[LW-1:0]);
    assign o_load_error = r_err;

endmodule

// ----- src/cds_mod400.sv -----
// remainder of a loaded year modulo 400: reciprocal multiply, then multiply back and subtract
module cds_mod400 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_value,
    output logic        o_done,
    output logic [8:0]  o_rem
);
    import cds_pkg::*;

    logic        r_stage;
    logic        r_done;
    logic [15:0] r_val;
    logic [7:0]  r_quo;
    logic [8:0]  r_rem;
    logic [32:0] w_prod;
    logic [15:0] w_back;
    logic [15:0] w_diff;

    // quotient by 400, at most 163 for a 16-bit value
    assign w_prod = 33'(i_value) * 33'(RECIP_400);
    assign w_back = 16'(r_quo) * 16'(MOD_YEARS);
    assign w_diff = r_val - w_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_quo <= w_prod[RECIP_SHIFT +: 8];
        end
        if (r_stage) begin
            r_rem <= w_diff[8:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- src/cds_step.sv -----
// one calendar step: next day, next month or next year
module cds_step #(
    parameter int unsigned YEAR_WIDTH = 16
) (
    input  cds_pkg::t_action        i_op,
    input  cds_pkg::t_date          i_date,
    input  logic [YEAR_WIDTH-1:0]   i_year,
    output cds_pkg::t_date          o_date,
    output logic [YEAR_WIDTH-1:0]   o_year
);
    import cds_pkg::*;

    logic                  w_leap;
    logic [4:0]            w_len;
    logic [4:0]            w_len_next;
    logic [3:0]            w_month_inc;
    logic [YEAR_WIDTH-1:0] w_year_inc;
    logic [8:0]            w_mod_inc;

    always_comb begin
        w_leap      = is_leap(i_date.mod400, i_year[1:0]);
        w_len       = month_len(i_date.month, w_leap);
        w_month_inc = i_date.month + 1'b1;
        w_len_next  = month_len(w_month_inc, w_leap);
        w_year_inc  = i_year + 1'b1;
        // the residue restarts after 399 and on a wrap to year 0
        if (&i_year || (i_date.mod400 == 9'(MOD_YEARS - 1))) begin
            w_mod_inc = '0;
        end else begin
            w_mod_inc = i_date.mod400 + 1'b1;
        end

        o_date = i_date;
        o_year = i_year;
        unique case (i_op)
            ACT_LOAD: begin
                o_date = i_date;
            end
            ACT_DAYS: begin
                if (i_date.day >= w_len) begin
                    o_date.day = DAY_FIRST;
                    if (i_date.month == MONTH_DEC) begin
                        o_date.month  = MONTH_JAN;
                        o_date.mod400 = w_mod_inc;
                        o_year        = w_year_inc;
                    end else begin
                        o_date.month = w_month_inc;
                    end
                end else begin
                    o_date.day = i_date.day + 1'b1;
                end
            end
            ACT_MONTH: begin
                if (i_date.month == MONTH_DEC) begin
                    // january is long enough for any day
                    o_date.month  = MONTH_JAN;
                    o_date.mod400 = w_mod_inc;
                    o_year        = w_year_inc;
                end else begin
                    o_date.month = w_month_inc;
                    if (i_date.day > w_len_next) begin
                        o_date.day = w_len_next;
                    end
                end
            end
            ACT_YEAR: begin
                if ((i_date.day == DAY_LEAP) && (i_date.month == MONTH_FEB)) begin
                    o_date.day = DAY_FEB_LAST;
                end
                o_date.mod400 = w_mod_inc;
                o_year        = w_year_inc;
            end
            default: begin
                o_date = i_date;
            end
        endcase
    end

endmodule
